// ----- hdl/mbe_pkg.sv -----
package mbe_pkg;

  localparam int TableSize = 4096;
  localparam int IdxW      = 12;
  localparam int ResW      = 30;
  localparam int MulLat    = 5;

  localparam logic [ResW-1:0] Prime     = 30'd1000000007;
  localparam logic [ResW-1:0] FermatExp = Prime - 30'd2;
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(TableSize - 1);

  // barrett factor floor(2^60 / prime)
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'd1000000007);

  typedef enum logic [1:0] {
    CMD_NCR     = 2'd0,
    CMD_NPR     = 2'd1,
    CMD_FACT    = 2'd2,
    CMD_INVFACT = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_FWD  = 4'b0001,
    ST_EXP  = 4'b0010,
    ST_BWD  = 4'b0100,
    ST_DONE = 4'b1000
  } fill_st_t;

endpackage

// ----- hdl/mbe_if.sv -----
interface mbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] count_n;
  logic signed [12:0] choose_r;
  modport source (output valid, command, count_n, choose_r, input ready);
  modport sink   (input valid, command, count_n, choose_r, output ready);
endinterface

interface mbe_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] residue;
  modport source (output valid, residue, input ready);
  modport sink   (input valid, residue, output ready);
endinterface

// ----- hdl/mbe_modmul.sv -----
module mbe_modmul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [mbe_pkg::ResW-1:0] a,
  input  logic [mbe_pkg::ResW-1:0] b,
  output logic                     out_vld,
  output logic [mbe_pkg::ResW-1:0] res
);

  localparam logic [31:0] P1 = 32'(mbe_pkg::Prime);
  localparam logic [31:0] P2 = 32'(mbe_pkg::Prime) << 1;

  logic [mbe_pkg::MulLat-1:0] vld_r;
  logic [59:0] prod_r;
  logic [61:0] est_r;
  logic [31:0] xlo2_r, xlo3_r, qp_r, rem_r;
  logic [mbe_pkg::ResW-1:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[mbe_pkg::MulLat-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 60'(a) * 60'(b);
      est_r  <= 62'(prod_r[59:29]) * 62'(mbe_pkg::BarrettMu);
      xlo2_r <= prod_r[31:0];
      // quotient estimate is at most two short, so only low bits matter
      qp_r   <= 32'(60'(est_r[60:31]) * 60'(mbe_pkg::Prime));
      xlo3_r <= xlo2_r;
      rem_r  <= xlo3_r - qp_r;
      if (rem_r >= P2) begin
        res_r <= mbe_pkg::ResW'(rem_r - P2);
      end else if (rem_r >= P1) begin
        res_r <= mbe_pkg::ResW'(rem_r - P1);
      end else begin
        res_r <= mbe_pkg::ResW'(rem_r);
      end
    end
  end

  assign out_vld = vld_r[mbe_pkg::MulLat-1];
  assign res     = res_r;

endmodule

// ----- hdl/modular_binomial_engine_core.sv -----
// Combinatorial residues modulo 1000000007: nCr, nPr, r! and (r!)^-1 for indices
// below 4096. After reset the block fills its factorial and inverse-factorial
// tables with one pipelined modular multiplier, one product at a time (4096 + 60 +
// 4095 products); in_chan.ready stays low until then. Afterwards it takes one query
// per cycle and returns each result through a table read, two chained 5-stage
// Barrett multipliers and an output register. A stall on the output holds the
// whole pipeline. Negative r, or r above n for nCr and nPr, returns 0.
module modular_binomial_engine_core (
  input  logic      clk,
  input  logic      rst_n,
  mbe_in_if.sink    in_chan,
  mbe_out_if.source out_chan
);

  localparam int RW = mbe_pkg::ResW;
  localparam int IW = mbe_pkg::IdxW;

  logic adv, busy, issue, accept;
  logic out_vld_r;
  logic [RW-1:0] out_res_r;

  mbe_pkg::fill_st_t state_r;
  logic [IW-1:0] idx_r;
  logic [RW-1:0] acc_r, pow_r, base_r, exp_r;
  logic sq_r, pend_r;

  logic [RW-1:0] fact_mem [mbe_pkg::TableSize];
  logic [RW-1:0] inv_mem  [mbe_pkg::TableSize];
  logic fact_we, inv_we;
  logic [IW-1:0] inv_wa;
  logic [RW-1:0] inv_wd;

  logic r_neg, zero;
  logic [IW-1:0] r_u, diff, fact_ra;
  logic [RW-1:0] fact_rd_r, inva_rd_r, invb_rd_r;
  logic q_vld_r, q_zero_r;
  mbe_pkg::cmd_t q_cmd_r;

  logic a_in_vld, a_out_vld, b_in_vld, b_out_vld;
  logic [RW-1:0] a_a, a_b, a_res, b_res;
  logic [RW-1:0] dly_r [mbe_pkg::MulLat];

  assign adv    = !out_vld_r || out_chan.ready;
  assign busy   = (state_r != mbe_pkg::ST_DONE);
  assign issue  = busy && !pend_r;
  assign in_chan.ready = adv && !busy;
  assign accept = in_chan.valid && in_chan.ready;

  // query decode
  assign r_neg = in_chan.choose_r[12];
  assign r_u   = in_chan.choose_r[11:0];
  assign diff  = in_chan.count_n - r_u;
  assign zero  = r_neg || ((in_chan.command == mbe_pkg::CMD_NCR ||
                            in_chan.command == mbe_pkg::CMD_NPR) &&
                           (r_u > in_chan.count_n));
  assign fact_ra = (in_chan.command == mbe_pkg::CMD_FACT) ? r_u : in_chan.count_n;

  // table fill writes
  assign fact_we = a_out_vld && (state_r == mbe_pkg::ST_FWD);
  always_comb begin
    inv_we = 1'b0;
    inv_wa = idx_r - IW'(1);
    inv_wd = a_res;
    if (a_out_vld && state_r == mbe_pkg::ST_BWD) begin
      inv_we = 1'b1;
    end else if (a_out_vld && state_r == mbe_pkg::ST_EXP && sq_r &&
                 exp_r[RW-1:1] == '0) begin
      inv_we = 1'b1;
      inv_wa = mbe_pkg::LastIdx;
      inv_wd = pow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fact_we) begin
      fact_mem[idx_r] <= a_res;
    end
    if (adv) begin
      fact_rd_r <= fact_mem[fact_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[inv_wa] <= inv_wd;
    end
    if (adv) begin
      inva_rd_r <= inv_mem[diff];
      invb_rd_r <= inv_mem[r_u];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else if (adv) begin
      q_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_cmd_r  <= mbe_pkg::cmd_t'(in_chan.command);
      q_zero_r <= zero;
    end
  end

  // fill sequencer: forward factorials, fermat power, backward inverses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbe_pkg::ST_FWD;
      idx_r   <= '0;
      acc_r   <= RW'(1);
      pend_r  <= 1'b0;
      sq_r    <= 1'b0;
    end else begin
      if (issue) begin
        pend_r <= 1'b1;
      end
      if (a_out_vld && busy) begin
        pend_r <= 1'b0;
        case (state_r)
          mbe_pkg::ST_FWD: begin
            acc_r <= a_res;
            if (idx_r == mbe_pkg::LastIdx) begin
              state_r <= mbe_pkg::ST_EXP;
              base_r  <= a_res;
              pow_r   <= RW'(1);
              exp_r   <= mbe_pkg::FermatExp;
              sq_r    <= 1'b0;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
          mbe_pkg::ST_EXP: begin
            if (!sq_r) begin
              pow_r <= a_res;
              sq_r  <= 1'b1;
            end else begin
              base_r <= a_res;
              exp_r  <= exp_r >> 1;
              sq_r   <= 1'b0;
              if (exp_r[RW-1:1] == '0) begin
                state_r <= mbe_pkg::ST_BWD;
                idx_r   <= mbe_pkg::LastIdx;
                acc_r   <= pow_r;
              end
            end
          end
          mbe_pkg::ST_BWD: begin
            acc_r <= a_res;
            if (idx_r == IW'(1)) begin
              state_r <= mbe_pkg::ST_DONE;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r - IW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // first multiplier is shared by the fill and the query path
  always_comb begin
    a_in_vld = q_vld_r;
    a_a = (q_cmd_r == mbe_pkg::CMD_INVFACT) ? invb_rd_r : fact_rd_r;
    a_b = (q_cmd_r == mbe_pkg::CMD_NCR || q_cmd_r == mbe_pkg::CMD_NPR) ?
          inva_rd_r : RW'(1);
    if (q_zero_r) begin
      a_a = '0;
    end
    if (busy) begin
      a_in_vld = issue;
      case (state_r)
        mbe_pkg::ST_FWD: begin
          a_a = acc_r;
          a_b = (idx_r == '0) ? RW'(1) : RW'(idx_r);
        end
        mbe_pkg::ST_EXP: begin
          a_a = sq_r ? base_r : pow_r;
          a_b = (sq_r || exp_r[0]) ? base_r : RW'(1);
        end
        default: begin
          a_a = acc_r;
          a_b = RW'(idx_r);
        end
      endcase
    end
  end

  mbe_modmul u_mul_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (a_in_vld),
    .a       (a_a),
    .b       (a_b),
    .out_vld (a_out_vld),
    .res     (a_res)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= (q_cmd_r == mbe_pkg::CMD_NCR) ? invb_rd_r : RW'(1);
      for (int k = 1; k < mbe_pkg::MulLat; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign b_in_vld = a_out_vld && !busy;

  mbe_modmul u_mul_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (b_in_vld),
    .a       (a_res),
    .b       (dly_r[mbe_pkg::MulLat-1]),
    .out_vld (b_out_vld),
    .res     (b_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= b_out_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= b_res;
    end
  end

  assign out_chan.valid   = out_vld_r;
  assign out_chan.residue = out_res_r;

endmodule

// ----- hdl/mbe_checker.sv -----
module mbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [29:0] out_residue
);

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_residue < 30'd1000000007))
    else $error("residue not reduced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped under stall");

  a_fill_block: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken before tables filled");

  a_no_spurious: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result without query after reset");

endmodule

bind modular_binomial_engine_core mbe_checker u_mbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_residue (out_chan.residue)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int NumRandom = 600;
  localparam int CalmFrom  = 520;
  localparam int PauseAt   = 300;
  localparam longint unsigned Modulus = 64'd1000000007;

  typedef struct {
    mbe_pkg::cmd_t      cmd;
    logic [11:0]        n;
    logic signed [12:0] r;
    bit                 known;
    logic [29:0]        value;
  } query_row_t;

  logic clk;
  logic rst_n;

  mbe_in_if  in_chan ();
  mbe_out_if out_chan ();

  modular_binomial_engine_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  longint unsigned fact_tab [mbe_pkg::TableSize];
  longint unsigned inv_fact_tab [mbe_pkg::TableSize];
  logic [29:0] pending_residues[$];
  int errors;
  int results_seen;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
    return (a * b) % Modulus;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex);
    longint unsigned acc;
    longint unsigned b;
    acc = 1;
    b = base % Modulus;
    while (ex != 0) begin
      if (ex[0]) acc = mul_mod(acc, b);
      b = mul_mod(b, b);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic void build_tables();
    fact_tab[0] = 1;
    for (int i = 1; i < mbe_pkg::TableSize; i++) fact_tab[i] = mul_mod(fact_tab[i-1], i);
    inv_fact_tab[mbe_pkg::TableSize-1] = pow_mod(fact_tab[mbe_pkg::TableSize-1],
                                                 Modulus - 2);
    for (int i = mbe_pkg::TableSize - 1; i > 0; i--)
      inv_fact_tab[i-1] = mul_mod(inv_fact_tab[i], i);
  endfunction

  function automatic logic [29:0] combinatoric_residue(mbe_pkg::cmd_t cmd, logic [11:0] n,
                                                       logic signed [12:0] r);
    int ni;
    int ri;
    longint unsigned t;
    ni = n;
    ri = r;
    if (ri < 0 || ri >= mbe_pkg::TableSize) return '0;
    case (cmd)
      mbe_pkg::CMD_FACT:    return fact_tab[ri][29:0];
      mbe_pkg::CMD_INVFACT: return inv_fact_tab[ri][29:0];
      default: begin
        if (ri > ni) return '0;
        t = mul_mod(fact_tab[ni], inv_fact_tab[ni-ri]);
        if (cmd == mbe_pkg::CMD_NCR) t = mul_mod(t, inv_fact_tab[ri]);
        return t[29:0];
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [29:0] got, logic [29:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one query: optional idle burst, then hold valid until the transfer
  task automatic send_query(mbe_pkg::cmd_t cmd, logic [11:0] n, logic signed [12:0] r,
                            bit known, logic [29:0] value);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.command  <= cmd;
    in_chan.count_n  <= n;
    in_chan.choose_r <= r;
    do @(posedge clk); while (!in_chan.ready);
    pending_residues.push_back(known ? value : combinatoric_residue(cmd, n, r));
  endtask

  // result side: random stalls, one long hold-off to back the pipeline up
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        if (pending_residues.size() == 0) begin
          report_mismatch("unexpected transfer", out_chan.residue, '0);
        end else begin
          logic [29:0] want;
          want = pending_residues.pop_front();
          if (out_chan.residue !== want) report_mismatch("residue", out_chan.residue, want);
        end
        results_seen++;
      end
      if (!held && results_seen >= 80) begin
        held = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    query_row_t rows[$];
    int k;
    logic [11:0] n;
    logic signed [12:0] r;
    errors = 0;
    results_seen = 0;
    calm = 0;
    build_tables();
    rst_n <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.command  <= mbe_pkg::CMD_NCR;
    in_chan.count_n  <= '0;
    in_chan.choose_r <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    rows = '{
      '{mbe_pkg::CMD_NCR,     12'd0,    13'sd0,     1, 30'd1},
      '{mbe_pkg::CMD_FACT,    12'd0,    13'sd0,     1, 30'd1},
      '{mbe_pkg::CMD_INVFACT, 12'd0,    13'sd0,     1, 30'd1},
      '{mbe_pkg::CMD_FACT,    12'd4095, 13'sd1,     1, 30'd1},
      '{mbe_pkg::CMD_NCR,     12'd5,    13'sd2,     1, 30'd10},
      '{mbe_pkg::CMD_NPR,     12'd5,    13'sd5,     1, 30'd120},
      '{mbe_pkg::CMD_NPR,     12'd4095, 13'sd0,     1, 30'd1},
      '{mbe_pkg::CMD_NCR,     12'd4095, 13'sd4095,  1, 30'd1},
      '{mbe_pkg::CMD_NCR,     12'd4095, 13'sd0,     1, 30'd1},
      '{mbe_pkg::CMD_NCR,     12'd4095, -13'sd1,    1, 30'd0},
      '{mbe_pkg::CMD_NPR,     12'd4095, -13'sd4096, 1, 30'd0},
      '{mbe_pkg::CMD_FACT,    12'd0,    -13'sd1,    1, 30'd0},
      '{mbe_pkg::CMD_INVFACT, 12'd4095, -13'sd4096, 1, 30'd0},
      '{mbe_pkg::CMD_NCR,     12'd3,    13'sd4,     1, 30'd0},
      '{mbe_pkg::CMD_NPR,     12'd0,    13'sd4095,  1, 30'd0},
      '{mbe_pkg::CMD_FACT,    12'd0,    13'sd4095,  0, 30'd0},
      '{mbe_pkg::CMD_INVFACT, 12'd7,    13'sd4095,  0, 30'd0},
      '{mbe_pkg::CMD_FACT,    12'd100,  13'sd12,    1, 30'd479001600},
      '{mbe_pkg::CMD_INVFACT, 12'd0,    13'sd1,     1, 30'd1},
      '{mbe_pkg::CMD_NCR,     12'd4095, 13'sd2048,  0, 30'd0},
      '{mbe_pkg::CMD_NPR,     12'd4095, 13'sd4094,  0, 30'd0},
      '{mbe_pkg::CMD_NPR,     12'd2730, 13'sd1365,  0, 30'd0}
    };
    foreach (rows[i]) send_query(rows[i].cmd, rows[i].n, rows[i].r,
                                 rows[i].known, rows[i].value);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == PauseAt) begin
        in_chan.valid <= 1'b0;
        while (pending_residues.size() != 0) @(posedge clk);
      end
      if (i == CalmFrom) calm = 1;
      k = $urandom_range(0, 9);
      if (k <= 6) begin
        n = 12'($urandom_range(0, (k < 4) ? 64 : 4095));
        r = 13'($urandom_range(0, n));
      end else if (k == 7) begin
        n = 12'($urandom_range(0, 4095));
        r = -$signed(13'($urandom_range(1, 4096)));
      end else if (k == 8) begin
        n = 12'($urandom_range(0, 4094));
        r = 13'($urandom_range(n + 1, 4095));
      end else begin
        n = 12'($urandom);
        r = 13'($urandom);
      end
      send_query(mbe_pkg::cmd_t'(2'($urandom_range(0, 3))), n, r, 0, '0);
    end
    in_chan.valid <= 1'b0;

    while (pending_residues.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
